// File: rtl/core/calendar_to_epoch_seconds_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the calendar to epoch seconds block
// Shared property forms, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH
`define CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH

// same-cycle implication
`define C2E_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define C2E_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/c2e_pkg.sv
// ----------------------------------------------------------------------------
// c2e_pkg
// Widths, constants, month tables and the date unit's result type.
// ----------------------------------------------------------------------------
package c2e_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int DAYS_W   = 23;  // holds the day count up to year 16383
   localparam int TOD_W    = 17;  // seconds within a day, up to 86399
   localparam int SECS_W   = 40;

   localparam logic [YEAR_W-1:0]   EPOCH_YEAR     = 14'd1970;
   localparam logic [DAYS_W-1:0]   LEAPS_AT_EPOCH = 23'd477;  // leaps_through(1970)
   localparam logic [DAYS_W-1:0]   DAYS_PER_YEAR  = 23'd365;
   localparam logic [MONTH_W-1:0]  FEBRUARY       = 4'd1;
   localparam logic [MONTH_W-1:0]  LAST_MONTH     = 4'd11;
   localparam logic [HOUR_W-1:0]   LAST_HOUR      = 5'd23;
   localparam logic [MINUTE_W-1:0] LAST_MINUTE    = 6'd59;
   localparam logic [SECOND_W-1:0] LAST_SECOND    = 6'd59;

   // year / 100 as (year * 5243) >> 19, exact over the 14-bit year range
   localparam int DIV100_MUL_W = 13;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_Q_W   = 8;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;

   localparam logic [TOD_W-1:0]  SECS_PER_HOUR   = 17'd3600;
   localparam logic [TOD_W-1:0]  SECS_PER_MINUTE = 17'd60;
   localparam logic [SECS_W-1:0] SECS_PER_DAY    = 40'd86400;

   typedef struct packed {
      logic              bad;
      logic [DAYS_W-1:0] days;
      logic [TOD_W-1:0]  tod;
   } c2e_date_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] mon);
      logic [DAY_W-1:0] len;
      unique case (mon)
         4'd1:                 len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:              len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mon);
      logic [8:0] d;
      unique case (mon)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/core/calendar_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Broken-down UTC date and time to seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// One result word per request word, in order. The block takes a word every
// cycle unless a stalled output has filled all stages. A word passes an input
// register, a register holding the day count and the seconds within the day,
// and the output register, with the scaling of days by 86400 between the last
// two. An invalid date or time gives all ones in rsp_tdata and rsp_tuser high.
// A stalled output holds its word while the earlier stages keep filling.
`include "calendar_to_epoch_seconds_defines.svh"

module calendar_to_epoch_seconds
   import c2e_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   // full_year[13:0], month_index[17:14], day_of_month[22:18],
   // hour_of_day[27:23], minute_of_hour[33:28], second_of_minute[39:34]
   input  logic [39:0]       req_tdata,

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // epoch_seconds[39:0], signed
   output logic [SECS_W-1:0] rsp_tdata,
   // is_invalid[0]
   output logic              rsp_tuser
);

   logic                a_valid_ff, a_valid_in;
   logic [39:0]         a_data_ff;
   logic                b_valid_ff, b_valid_in;
   c2e_date_type        b_date_ff;
   logic                c_valid_ff, c_valid_in;
   logic [SECS_W-1:0]   c_secs_ff, c_secs_in;
   logic                c_bad_ff;

   logic                a_free, b_free, c_free;
   c2e_date_type        date;

   c2e_date_unit u_date (
      .year   (a_data_ff[13:0]),
      .month  (a_data_ff[17:14]),
      .day    (a_data_ff[22:18]),
      .hour   (a_data_ff[27:23]),
      .minute (a_data_ff[33:28]),
      .second (a_data_ff[39:34]),
      .date   (date)
   );

   // a stage may load when it is empty or its word moves on
   always_comb begin
      c_free     = !c_valid_ff || rsp_tready;
      b_free     = !b_valid_ff || c_free;
      a_free     = !a_valid_ff || b_free;
      a_valid_in = a_free ? req_tvalid : a_valid_ff;
      b_valid_in = b_free ? a_valid_ff : b_valid_ff;
      c_valid_in = c_free ? b_valid_ff : c_valid_ff;
      c_secs_in  = b_date_ff.bad ? {SECS_W{1'b1}}
                 : SECS_W'(b_date_ff.days) * SECS_PER_DAY + SECS_W'(b_date_ff.tod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && req_tvalid) begin
         a_data_ff <= req_tdata;
      end
      if (b_free && a_valid_ff) begin
         b_date_ff <= date;
      end
      if (c_free && b_valid_ff) begin
         c_secs_ff <= c_secs_in;
         c_bad_ff  <= b_date_ff.bad;
      end
   end

   assign req_tready = a_free;
   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = c_secs_ff;
   assign rsp_tuser  = c_bad_ff;

   `C2E_ASSERT_NOW(a_invalid_all_ones, rsp_tvalid && rsp_tuser,
      rsp_tdata == {SECS_W{1'b1}}, "invalid word without all-ones seconds")
   `C2E_ASSERT_NOW(a_valid_non_negative, rsp_tvalid && !rsp_tuser,
      !rsp_tdata[SECS_W-1], "valid word with negative seconds")
   `C2E_ASSERT_NEXT(a_accept_loads, req_tvalid && req_tready,
      a_valid_ff, "accepted word not held in input stage")
   `C2E_ASSERT_NEXT(a_advance_to_output, b_valid_ff && c_free,
      c_valid_ff, "day stage word lost on the way to the output")

endmodule

// File: rtl/core/c2e_date_unit.sv
// ----------------------------------------------------------------------------
// c2e_date_unit
// Field checks, Gregorian leap rule and day count since the epoch, plus the
// seconds within the day.
// ----------------------------------------------------------------------------
module c2e_date_unit
   import c2e_pkg::*;
(
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   input  logic [DAY_W-1:0]    day,
   input  logic [HOUR_W-1:0]   hour,
   input  logic [MINUTE_W-1:0] minute,
   input  logic [SECOND_W-1:0] second,
   output c2e_date_type        date
);

   logic [YEAR_W+DIV100_MUL_W-1:0] div_prod;
   logic [DIV100_Q_W-1:0]          q100;
   logic [YEAR_W-1:0]              hundreds;
   logic                           century;
   logic                           leap;
   logic [YEAR_W-3:0]              leaps;
   logic [DAY_W-1:0]               len;
   logic [YEAR_W-1:0]              year_off;
   logic                           adj;

   always_comb begin
      div_prod = {{DIV100_MUL_W{1'b0}}, year} * {{YEAR_W{1'b0}}, DIV100_MUL};
      q100     = div_prod[YEAR_W+DIV100_MUL_W-1:DIV100_SHIFT];
      hundreds = YEAR_W'(q100) * YEAR_W'(100);
      century  = (hundreds == year);
      leap     = (year[1:0] == 2'b00) && (!century || (q100[1:0] == 2'b00));
      // leaps_through(year) = y/4 - y/100 + y/400
      leaps    = year[YEAR_W-1:2] - (YEAR_W-2)'(q100)
                 + (YEAR_W-2)'(q100[DIV100_Q_W-1:2]);

      len = month_length(month) + DAY_W'(leap && (month == FEBRUARY));

      date.bad = (year < EPOCH_YEAR) || (month > LAST_MONTH) || (day == '0)
                 || (day > len) || (hour > LAST_HOUR) || (minute > LAST_MINUTE)
                 || (second > LAST_SECOND);

      // drop this year's leap day until March
      adj       = leap && (month <= FEBRUARY);
      year_off  = year - EPOCH_YEAR;
      date.days = DAYS_W'(year_off) * DAYS_PER_YEAR
                  + DAYS_W'(days_before(month))
                  + DAYS_W'(day) - DAYS_W'(1)
                  + DAYS_W'(leaps) - LEAPS_AT_EPOCH
                  - DAYS_W'(adj);

      date.tod = TOD_W'(hour) * SECS_PER_HOUR + TOD_W'(minute) * SECS_PER_MINUTE
                 + TOD_W'(second);
   end

endmodule
